>>> rtl/qnorm_pkg.sv
// Shared constants for the quaternion normalizer.
// No dependencies.
`default_nettype none
package qnorm_pkg;
  localparam int CompW = 16;
  localparam int SqW = 31;
  localparam int SumW = 34;
  localparam int QW = 15;
  localparam logic [CompW-1:0] UnitOne = 16'd16384;
  // the test d*d*s <= m*m*2^30 is kept exact: d up to 2^15, s up to 2^32,
  // and the running products q*s and q*q*s stay below 2^61
  localparam int LhsW = 64;
endpackage
`default_nettype wire

>>> rtl/quaternion_normalize.sv
// Pipelined quaternion normalizer: squares and sum, then a root-free
// quotient search, one register stage per quotient bit.
// Depends on qnorm_pkg and qnorm_bit.
`default_nettype none
// Pipeline: 17 register stages (sum stage, fifteen quotient-bit stages, sign
// stage). One word per cycle throughput while the output is not stalled. A
// stall at the output freezes the whole pipeline; ready is low only then.
// Synchronous active-low reset clears all stage valid bits.
module quaternion_normalize (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_ready,
  input  wire logic signed [15:0] in_comp_x,
  input  wire logic signed [15:0] in_comp_y,
  input  wire logic signed [15:0] in_comp_z,
  input  wire logic signed [15:0] in_comp_w,
  output logic      out_valid,
  input  wire logic out_ready,
  output logic signed [15:0] out_unit_x,
  output logic signed [15:0] out_unit_y,
  output logic signed [15:0] out_unit_z,
  output logic signed [15:0] out_unit_w,
  output logic      out_zero_length
);
  localparam int Steps = qnorm_pkg::QW;
  localparam int NS = Steps + 1;
  logic [NS:0] vld_r;
  logic [3:0][qnorm_pkg::SqW-1:0]  sq_r  [NS];
  logic [3:0]                      neg_r [NS];
  logic [qnorm_pkg::SumW-1:0]      sum_r [NS];
  logic [3:0][qnorm_pkg::QW-1:0]   q_r   [NS];
  logic [3:0][qnorm_pkg::LhsW-1:0] a_r   [NS];
  logic [3:0][qnorm_pkg::LhsW-1:0] b_r   [NS];
  logic [3:0][qnorm_pkg::QW-1:0]   q_nxt [Steps];
  logic [3:0][qnorm_pkg::LhsW-1:0] a_nxt [Steps];
  logic [3:0][qnorm_pkg::LhsW-1:0] b_nxt [Steps];
  logic [3:0][15:0] res_r;
  logic zl_r;
  logic adv;
  logic [3:0][15:0] cin;
  logic [3:0][31:0] sq_nxt;
  logic [qnorm_pkg::SumW-1:0] sum_nxt;

  // advance whenever the output word is free or being taken
  assign adv = !out_valid || out_ready;
  assign in_ready = adv;
  assign cin = {in_comp_w, in_comp_z, in_comp_y, in_comp_x};

  // square each component at full width and sum the squares
  always_comb begin
    sum_nxt = '0;
    for (int i = 0; i < 4; i++) begin
      sq_nxt[i] = 32'($signed({{16{cin[i][15]}}, cin[i]})
                    * $signed({{16{cin[i][15]}}, cin[i]}));
      sum_nxt = sum_nxt + qnorm_pkg::SumW'(sq_nxt[i]);
    end
  end

  // stage 0: squares, signs, sum of squares
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 4; i++) begin
        neg_r[0][i] <= cin[i][15];
        sq_r[0][i] <= sq_nxt[i][qnorm_pkg::SqW-1:0];
      end
      sum_r[0] <= sum_nxt;
      q_r[0] <= '0;
      a_r[0] <= '0;
      b_r[0] <= '0;
    end
  end

  // quotient-bit stages, most significant first
  for (genvar s = 0; s < Steps; s++) begin : g_stage
    for (genvar c = 0; c < 4; c++) begin : g_comp
      qnorm_bit #(.Bit(Steps - 1 - s)) u_bit (
        .q_in(q_r[s][c]), .a_in(a_r[s][c]), .b_in(b_r[s][c]),
        .sq(sq_r[s][c]), .sum(sum_r[s]),
        .q_out(q_nxt[s][c]), .a_out(a_nxt[s][c]), .b_out(b_nxt[s][c])
      );
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        q_r[s+1] <= q_nxt[s];
        a_r[s+1] <= a_nxt[s];
        b_r[s+1] <= b_nxt[s];
        sq_r[s+1] <= sq_r[s];
        neg_r[s+1] <= neg_r[s];
        sum_r[s+1] <= sum_r[s];
      end
    end
  end

  // final stage: apply sign, handle zero length
  always_ff @(posedge clk) begin
    if (adv) begin
      zl_r <= (sum_r[NS-1] == '0);
      for (int i = 0; i < 4; i++) begin
        if (sum_r[NS-1] == '0)
          res_r[i] <= (i == 0) ? qnorm_pkg::UnitOne : 16'd0;
        else
          res_r[i] <= neg_r[NS-1][i] ? 16'(-$signed({1'b0, q_r[NS-1][i]}))
                                     : 16'(q_r[NS-1][i]);
      end
    end
  end

  // valid bits travel with the data
  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else if (adv) vld_r <= {vld_r[NS-1:0], in_valid};
  end

  assign out_valid = vld_r[NS];
  assign out_unit_x = res_r[0];
  assign out_unit_y = res_r[1];
  assign out_unit_z = res_r[2];
  assign out_unit_w = res_r[3];
  assign out_zero_length = zl_r;

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(res_r))
    else $error("output word changed under stall");
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready == (!out_valid || out_ready))
    else $error("ready mismatch");
  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_zero_length |-> out_unit_x == qnorm_pkg::UnitOne)
    else $error("zero fallback wrong");
endmodule
`default_nettype wire

>>> rtl/qnorm_bit.sv
// One quotient-bit step of the scaled quotient for one component, built
// from shifts and adds on the running products q*s and q*q*s.
// Depends on qnorm_pkg.
`default_nettype none
module qnorm_bit #(
  parameter int Bit = 14
) (
  input  wire logic [qnorm_pkg::QW-1:0]   q_in,
  input  wire logic [qnorm_pkg::LhsW-1:0] a_in,
  input  wire logic [qnorm_pkg::LhsW-1:0] b_in,
  input  wire logic [qnorm_pkg::SqW-1:0]  sq,
  input  wire logic [qnorm_pkg::SumW-1:0] sum,
  output logic [qnorm_pkg::QW-1:0]        q_out,
  output logic [qnorm_pkg::LhsW-1:0]      a_out,
  output logic [qnorm_pkg::LhsW-1:0]      b_out
);
  logic [qnorm_pkg::LhsW-1:0] s64;
  logic [qnorm_pkg::LhsW-1:0] lhs;
  logic [qnorm_pkg::LhsW-1:0] rhs;
  logic                       take;

  // try setting this bit: with d = 2q + (2^(Bit+1) - 1),
  // d*d*s = 4*q*q*s + 4*(2^(Bit+1) - 1)*q*s + (2^(Bit+1) - 1)^2*s;
  // stop once the result reached one
  always_comb begin
    s64 = qnorm_pkg::LhsW'(sum);
    lhs = (b_in << 2) + (a_in << (Bit + 3)) - (a_in << 2)
        + (s64 << (2 * Bit + 2)) - (s64 << (Bit + 2)) + s64;
    rhs = qnorm_pkg::LhsW'(sq) << 30;
    take = (q_in < qnorm_pkg::QW'(qnorm_pkg::UnitOne)) && (lhs <= rhs);
    if (take) begin
      q_out = q_in | qnorm_pkg::QW'(1 << Bit);
      a_out = a_in + (s64 << Bit);
      b_out = b_in + (a_in << (Bit + 1)) + (s64 << (2 * Bit));
    end else begin
      q_out = q_in;
      a_out = a_in;
      b_out = b_in;
    end
  end
endmodule
`default_nettype wire
